// ----- src/gopd_pkg.sv -----
// Package for the gait oscillator PD joint torque generator.
// Holds the item codes, the controller and datapath types and the sine table.
// It depends on nothing else; every other file of the block uses it.
package gopd_pkg;

	localparam int MAX_HELD_JOINTS = 16;
	localparam int HELD_IDX_W      = 4;
	localparam int SINE_DEPTH      = 256;
	localparam int SINE_IDX_W      = $clog2(SINE_DEPTH);
	localparam int ACC_W           = 60;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 31;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CAPTURE = 2'd1,
		OP_DRIVE   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		GRP_A    = 2'd0,
		GRP_B    = 2'd1,
		GRP_HELD = 2'd2
	} group_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_DDT  = 3'd1,
		CFG_AMPLITUDE = 3'd2,
		CFG_PHASE_STEP = 3'd3,
		CFG_DEADBAND  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STEP1,
		ST_STEP2,
		ST_STEP3,
		ST_FINISH,
		ST_ZERO
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_TICK,
		DP_CAPTURE,
		DP_FETCH,
		DP_MV_PROD,
		DP_MV_DIFF,
		DP_MV_SCALE,
		DP_HD_DIFF,
		DP_HD_PTERM,
		DP_HD_DTERM,
		DP_FINISH,
		DP_ZERO
	} dp_op_t;

	typedef struct packed {
		logic   take_item;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_active;
	} dp_status_t;

	typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

	function automatic logic held_in_range(input logic [HELD_IDX_W-1:0] idx);
		held_in_range = ({1'b0, idx} < (HELD_IDX_W+1)'(MAX_HELD_JOINTS));
	endfunction

	// Odd ninth-order polynomial for the sine of a 16-bit turn fraction, Q1.15.
	function automatic logic signed [15:0] poly_sine(input logic [15:0] ang);
		logic [1:0]  quad;
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] s;
		logic [63:0] r;
		quad = ang[15:14];
		x = {50'd0, ang[13:0]};
		if (quad[0]) begin
			x = 64'd16384 - x;
		end
		t  = x << 16;
		t2 = (t * t) >> 30;
		s  = 64'd172271;
		s  = 64'd5026994 - ((s * t2) >> 30);
		s  = 64'd85569306 - ((s * t2) >> 30);
		s  = 64'd693598669 - ((s * t2) >> 30);
		s  = 64'd1686629713 - ((s * t2) >> 30);
		r  = (s * t) >> 30;
		r  = (r + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		poly_sine = quad[1] ? -$signed(r[15:0]) : $signed(r[15:0]);
	endfunction

	function automatic sine_tab_t build_sine_table();
		sine_tab_t tab;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			tab[i] = poly_sine(16'(i << (16 - SINE_IDX_W)));
		end
		build_sine_table = tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

// ----- src/gopd_ctrl.sv -----
// Controller state machine of the gait oscillator PD joint torque generator.
// Sequences the datapath steps of a drive item and owns the handshake flags.
// Depends on gopd_pkg.
module gopd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            opcode,
	input  logic [1:0]            joint_group,
	input  logic [gopd_pkg::HELD_IDX_W-1:0] held_index,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  gopd_pkg::dp_status_t  status,
	output gopd_pkg::dp_cmd_t     cmd
);

	gopd_pkg::state_t state_q;
	gopd_pkg::state_t state_d;
	logic             held_q;
	logic             held_d;
	logic             m_tvalid_q;
	logic             out_free;
	logic             out_load;
	logic             mv_go;
	logic             hd_go;

	assign out_free = !m_tvalid_q || m_tready;
	assign mv_go = (joint_group == gopd_pkg::GRP_A || joint_group == gopd_pkg::GRP_B)
		&& status.walk_active;
	assign hd_go = (joint_group == gopd_pkg::GRP_HELD) && gopd_pkg::held_in_range(held_index);

	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		case (state_q)
			gopd_pkg::ST_IDLE: begin
				if (s_tvalid && opcode == gopd_pkg::OP_DRIVE) begin
					if (mv_go) begin
						state_d = gopd_pkg::ST_FETCH;
						held_d  = 1'b0;
					end else if (hd_go) begin
						state_d = gopd_pkg::ST_FETCH;
						held_d  = 1'b1;
					end else begin
						state_d = gopd_pkg::ST_ZERO;
					end
				end
			end
			gopd_pkg::ST_FETCH: state_d = gopd_pkg::ST_STEP1;
			gopd_pkg::ST_STEP1: state_d = gopd_pkg::ST_STEP2;
			gopd_pkg::ST_STEP2: state_d = gopd_pkg::ST_STEP3;
			gopd_pkg::ST_STEP3: state_d = gopd_pkg::ST_FINISH;
			gopd_pkg::ST_FINISH, gopd_pkg::ST_ZERO: begin
				if (out_free) begin
					state_d = gopd_pkg::ST_IDLE;
				end
			end
			default: state_d = gopd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.take_item = 1'b0;
		cmd.op        = gopd_pkg::DP_NOP;
		out_load      = 1'b0;
		case (state_q)
			gopd_pkg::ST_IDLE: begin
				cmd.take_item = s_tvalid;
				if (s_tvalid && opcode == gopd_pkg::OP_TICK) begin
					cmd.op = gopd_pkg::DP_TICK;
				end else if (s_tvalid && opcode == gopd_pkg::OP_CAPTURE) begin
					cmd.op = gopd_pkg::DP_CAPTURE;
				end
			end
			gopd_pkg::ST_FETCH: cmd.op = gopd_pkg::DP_FETCH;
			gopd_pkg::ST_STEP1: cmd.op = held_q ? gopd_pkg::DP_HD_DIFF : gopd_pkg::DP_MV_PROD;
			gopd_pkg::ST_STEP2: cmd.op = held_q ? gopd_pkg::DP_HD_PTERM : gopd_pkg::DP_MV_DIFF;
			gopd_pkg::ST_STEP3: cmd.op = held_q ? gopd_pkg::DP_HD_DTERM : gopd_pkg::DP_MV_SCALE;
			gopd_pkg::ST_FINISH: begin
				out_load = out_free;
				cmd.op   = out_free ? gopd_pkg::DP_FINISH : gopd_pkg::DP_NOP;
			end
			gopd_pkg::ST_ZERO: begin
				out_load = out_free;
				cmd.op   = out_free ? gopd_pkg::DP_ZERO : gopd_pkg::DP_NOP;
			end
			default: cmd.op = gopd_pkg::DP_NOP;
		endcase
	end

	assign s_tready = (state_q == gopd_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gopd_pkg::ST_IDLE;
			held_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/gopd_datapath.sv -----
// Datapath of the gait oscillator PD joint torque generator: configuration
// registers, gait phase, held joint stores, shared multiplier and output register.
// Depends on gopd_pkg; driven by gopd_ctrl through the command struct.
module gopd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gopd_pkg::dp_cmd_t                     cmd,
	output gopd_pkg::dp_status_t                  status,
	input  logic                                  cfg_we,
	input  logic [gopd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gopd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [15:0]                    stick_y,
	input  logic [1:0]                            joint_group,
	input  logic [gopd_pkg::HELD_IDX_W-1:0]       held_index,
	input  logic signed [31:0]                    joint_angle,
	output logic signed [31:0]                    torque,
	output logic                                  saturated
);

	localparam int RND_W = gopd_pkg::ACC_W - 8;
	localparam logic signed [RND_W-1:0] TQ_MAX = {{(RND_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [RND_W-1:0] TQ_MIN = {{(RND_W-31){1'b1}}, {31{1'b0}}};

	logic [15:0] gain_p_q;
	logic [23:0] gain_ddt_q;
	logic [30:0] amplitude_q;
	logic [15:0] phase_step_q;
	logic [14:0] deadband_q;
	logic [15:0] gait_phase_q;
	logic        walk_active_q;

	logic [1:0]                        group_q;
	logic [gopd_pkg::HELD_IDX_W-1:0]   hidx_q;
	logic signed [31:0]                angle_q;

	logic signed [31:0] ref_mem [gopd_pkg::MAX_HELD_JOINTS];
	logic signed [31:0] prev_mem [gopd_pkg::MAX_HELD_JOINTS];
	logic signed [31:0] ref_q;
	logic signed [31:0] prev_q;

	logic signed [15:0]               sine_q;
	logic signed [gopd_pkg::ACC_W-1:0] acc_q;
	logic signed [33:0]               diff_q;
	logic signed [33:0]               diff2_q;
	logic signed [31:0]               torque_q;
	logic                             saturated_q;

	logic [16:0]                      stick_mag;
	logic [15:0]                      phase_sel;
	logic signed [32:0]               mul_a;
	logic signed [33:0]               mul_b;
	logic signed [66:0]               mul_p;
	logic signed [gopd_pkg::ACC_W-1:0] sum15;
	logic signed [gopd_pkg::ACC_W-1:0] sum8;
	logic signed [RND_W-1:0]          rnd8;
	logic signed [33:0]               angle_x;

	assign stick_mag = stick_y[15] ? (17'd65536 - {1'b0, stick_y}) : {1'b0, stick_y};
	assign phase_sel = (group_q == gopd_pkg::GRP_B) ? (gait_phase_q + 16'h8000) : gait_phase_q;
	assign angle_x   = {{2{angle_q[31]}}, angle_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			gopd_pkg::DP_MV_PROD: begin
				mul_a = $signed({2'b00, amplitude_q});
				mul_b = {{18{sine_q[15]}}, sine_q};
			end
			gopd_pkg::DP_MV_SCALE, gopd_pkg::DP_HD_PTERM: begin
				mul_a = $signed({17'd0, gain_p_q});
				mul_b = diff_q;
			end
			gopd_pkg::DP_HD_DTERM: begin
				mul_a = $signed({9'd0, gain_ddt_q});
				mul_b = diff2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign sum15 = acc_q + $signed(gopd_pkg::ACC_W'(1 << 14));
	assign sum8  = acc_q + $signed(gopd_pkg::ACC_W'(1 << 7));
	assign rnd8  = $signed(sum8[gopd_pkg::ACC_W-1:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= 16'd25600;
			gain_ddt_q    <= 24'd2560000;
			amplitude_q   <= 31'd2949120;
			phase_step_q  <= 16'd33;
			deadband_q    <= 15'd6554;
			gait_phase_q  <= '0;
			walk_active_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gopd_pkg::CFG_GAIN_P:     gain_p_q     <= cfg_data[15:0];
					gopd_pkg::CFG_GAIN_DDT:   gain_ddt_q   <= cfg_data[23:0];
					gopd_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_data[30:0];
					gopd_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data[15:0];
					gopd_pkg::CFG_DEADBAND:   deadband_q   <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.op == gopd_pkg::DP_TICK) begin
				if (stick_mag > {2'b00, deadband_q}) begin
					gait_phase_q  <= gait_phase_q + phase_step_q;
					walk_active_q <= 1'b1;
				end else begin
					walk_active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gopd_pkg::DP_CAPTURE && gopd_pkg::held_in_range(held_index)) begin
			ref_mem[held_index]  <= joint_angle;
			prev_mem[held_index] <= joint_angle;
		end else if (cmd.op == gopd_pkg::DP_HD_DIFF) begin
			prev_mem[hidx_q] <= angle_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gopd_pkg::DP_FETCH) begin
			ref_q  <= ref_mem[hidx_q];
			prev_q <= prev_mem[hidx_q];
			sine_q <= gopd_pkg::SINE_TABLE[phase_sel[15 -: gopd_pkg::SINE_IDX_W]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			group_q <= joint_group;
			hidx_q  <= held_index;
			angle_q <= joint_angle;
		end
		case (cmd.op)
			gopd_pkg::DP_MV_PROD, gopd_pkg::DP_MV_SCALE, gopd_pkg::DP_HD_PTERM: begin
				acc_q <= mul_p[gopd_pkg::ACC_W-1:0];
			end
			gopd_pkg::DP_HD_DTERM: begin
				acc_q <= acc_q - mul_p[gopd_pkg::ACC_W-1:0];
			end
			gopd_pkg::DP_MV_DIFF: begin
				diff_q <= $signed(sum15[48:15]) - angle_x;
			end
			gopd_pkg::DP_HD_DIFF: begin
				diff_q  <= {{2{ref_q[31]}}, ref_q} - angle_x;
				diff2_q <= angle_x - {{2{prev_q[31]}}, prev_q};
			end
			gopd_pkg::DP_FINISH: begin
				if (rnd8 > TQ_MAX) begin
					torque_q    <= TQ_MAX[31:0];
					saturated_q <= 1'b1;
				end else if (rnd8 < TQ_MIN) begin
					torque_q    <= TQ_MIN[31:0];
					saturated_q <= 1'b1;
				end else begin
					torque_q    <= rnd8[31:0];
					saturated_q <= 1'b0;
				end
			end
			gopd_pkg::DP_ZERO: begin
				torque_q    <= '0;
				saturated_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign status.walk_active = walk_active_q;
	assign torque             = torque_q;
	assign saturated          = saturated_q;

endmodule

// ----- src/gait_oscillator_pd_joint_control.sv -----
// Top level of the gait oscillator PD joint torque generator.
// Joins the controller (gopd_ctrl) and the datapath (gopd_datapath); uses gopd_pkg.
//
// Items arrive on the s_ stream: s_tuser carries the opcode (tick, capture or
// drive) and s_tdata the stick, group, held index and joint angle. A tick item
// updates the gait phase and the walking flag; a capture item stores a held
// joint's reference. Both leave the input ready and give no result. A drive
// item gives one torque item on the m_ stream, with the clip flag in m_tuser.
// A drive item of a walking or held joint passes through six controller
// states, the shared 33 by 34 bit multiplier being used in two of them; it
// occupies the input through the fetch, step and finish states, and its result
// is registered in the finish state once the output register is free. A drive
// that yields zero torque goes to the zero state instead and is registered there.
// The output register holds one finished item; the block accepts new items
// while it waits, but the next drive stalls in its last step until the
// receiver has taken the previous result.
// Reset clears the gait phase, the walking flag and the handshake state and
// restores the register defaults; held joint entries must be captured before
// they are driven. Configuration writes through cfg_we take effect at once.
module gait_oscillator_pd_joint_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // stick_y[15:0], joint_group[17:16],
	                              // held_index[21:18], joint_angle[53:22], zeros
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // torque[31:0]
	output logic        m_tuser,  // saturated[0]
	input  logic        cfg_we,
	input  logic [gopd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gopd_pkg::CFG_DATA_W-1:0] cfg_data
);

	gopd_pkg::dp_cmd_t    cmd;
	gopd_pkg::dp_status_t status;
	logic signed [31:0]   torque;

	gopd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.opcode     (s_tuser),
		.joint_group(s_tdata[17:16]),
		.held_index (s_tdata[21:18]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.status     (status),
		.cmd        (cmd)
	);

	gopd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.stick_y    ($signed(s_tdata[15:0])),
		.joint_group(s_tdata[17:16]),
		.held_index (s_tdata[21:18]),
		.joint_angle($signed(s_tdata[53:22])),
		.torque     (torque),
		.saturated  (m_tuser)
	);

	assign m_tdata = torque;

endmodule

// ----- src/gopd_checker.sv -----
// Port-level checker for the gait oscillator PD joint torque generator.
// Depends on gopd_pkg; bound to the top level by the statement at the end.
module gopd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result item dropped before it was taken.");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 32'h7FFFFFFF || m_tdata == 32'h80000000))
		else $error("Clipped torque is not at a limit.");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == gopd_pkg::OP_DRIVE |=> !s_tready)
		else $error("Drive item did not occupy the block.");

	a_quick_items: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != gopd_pkg::OP_DRIVE |=> s_tready)
		else $error("Tick or capture item stalled the input.");

endmodule

bind gait_oscillator_pd_joint_control gopd_checker u_gopd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
